/* rtl/core/wrp_pkg.sv */
// Shared types, constants and the CRC-32 byte update for the WAL record parser.
package wrp_pkg;

   // Header layout, byte positions inside the 21-byte header
   localparam int HDR_BYTES = 21;
   localparam int HCNT_W    = 5;
   localparam logic [HCNT_W-1:0] HC_LOG  = 5'd4;
   localparam logic [HCNT_W-1:0] HC_SEG  = 5'd8;
   localparam logic [HCNT_W-1:0] HC_TYPE = 5'd16;
   localparam logic [HCNT_W-1:0] HC_SIZE = 5'd17;
   localparam logic [HCNT_W-1:0] HC_LAST = HCNT_W'(HDR_BYTES - 1);

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Result queue
   localparam int QDEPTH = 3;
   localparam int QCNT_W = 2;

   localparam int RSP_DATA_W = 368;

   // Config register indexes
   localparam logic CSR_CRC_EN  = 1'b0;
   localparam logic CSR_TS_CODE = 1'b1;

   typedef enum logic [1:0] {
      KIND_OK    = 2'd0,
      KIND_EOF   = 2'd1,
      KIND_TRUNC = 2'd2,
      KIND_CRC   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_ERROR   = 3'b100
   } phase_type;

   // Result fields, last field (log_number) in the low bits
   typedef struct packed {
      logic [63:0] cut_offset;
      logic [63:0] latest_ts_segment;
      logic [63:0] top_segment;
      logic [31:0] next_log_number;
      logic        newer_timestamp;
      logic        number_gap;
      logic [31:0] payload_size;
      logic [7:0]  entry_type;
      logic [63:0] record_segment;
      logic [31:0] log_number;
   } rsp_fields_type;

   typedef struct packed {
      logic           last;
      kind_type       kind;
      rsp_fields_type f;
   } beat_type;

   // Reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

/* rtl/core/wal_record_parser_crc_check.sv */
// WAL record parser top level: header framing, CRC-32 check and result queue.
// A result beat is written into the result queue as its req byte is taken.
// Throughput: one byte per cycle while req_tready is high; a byte that ends a record
//   and the file gives two beats, both pushed together into the 3-entry result queue.
// req_tready drops only while two or more result beats are queued, so a two-beat
//   byte holds req off until a beat is popped, even with rsp_tready high.
// Reset is synchronous: parse state, counters and the queue count clear,
//   crc_enable returns to 1 and timestamp_type_code to 0.
module wal_record_parser_crc_check (
   input  logic                            clock,
   input  logic                            reset,
   // byte stream in
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] data_byte
   input  logic                            req_tlast,   // end_of_file
   // result beats out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] log_number, [95:32] record_segment, [103:96] entry_type,
   // [135:104] payload_size, [136] number_gap, [137] newer_timestamp,
   // [169:138] next_log_number, [233:170] top_segment,
   // [297:234] latest_ts_segment, [361:298] cut_offset, rest zero
   output logic [wrp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                      rsp_tuser,   // kind
   output logic                            rsp_tlast,   // final_result
   // config writes
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [7:0]                      csr_wdata
);
   import wrp_pkg::*;

   // config
   logic        crc_enable_ff;
   logic [7:0]  ts_code_ff;

   // parse state
   phase_type          phase_ff, phase_in;
   logic [HCNT_W-1:0]  header_count_ff, header_count_in;
   logic [31:0]        header_crc_ff, header_crc_in;
   logic [31:0]        header_log_ff, header_log_in;
   logic [63:0]        header_seg_ff, header_seg_in;
   logic [7:0]         header_type_ff, header_type_in;
   logic [31:0]        header_size_ff, header_size_in;
   logic [31:0]        payload_left_ff, payload_left_in;
   logic [31:0]        running_crc_ff, running_crc_in;
   logic [31:0]        expected_ff, expected_in;
   logic [63:0]        highest_ff, highest_in;
   logic [63:0]        ts_segment_ff, ts_segment_in;
   logic [63:0]        byte_offset_ff, byte_offset_in;
   logic [63:0]        record_start_ff, record_start_in;

   // result queue, entry 0 is the head
   beat_type           q_ff [QDEPTH];
   beat_type           q_in [QDEPTH];
   beat_type           q_shift [QDEPTH];
   logic [QCNT_W-1:0]  count_ff, count_in, cnt_mid;

   logic        req_accept, pop;
   logic        done, gap, newer;
   logic [31:0] crc_base;
   logic [7:0]  b;
   beat_type    res_a, res_b, eof_res;
   logic [1:0]  n_res;

   function automatic beat_type mk_beat(
      input kind_type    kind,
      input logic        hdr,
      input logic [31:0] log_n,
      input logic [63:0] seg,
      input logic [7:0]  etype,
      input logic [31:0] size,
      input logic        g,
      input logic        nw,
      input logic [31:0] nxt,
      input logic [63:0] top,
      input logic [63:0] ts,
      input logic [63:0] cut
   );
      beat_type r;
      r.last                = 1'b0;
      r.kind                = kind;
      r.f.log_number        = hdr ? log_n : 32'd0;
      r.f.record_segment    = hdr ? seg : 64'd0;
      r.f.entry_type        = hdr ? etype : 8'd0;
      r.f.payload_size      = hdr ? size : 32'd0;
      r.f.number_gap        = g;
      r.f.newer_timestamp   = nw;
      r.f.next_log_number   = nxt;
      r.f.top_segment       = top;
      r.f.latest_ts_segment = ts;
      r.f.cut_offset        = cut;
      return r;
   endfunction

   // room for the worst case of two beats per byte
   assign req_tready = (count_ff < QCNT_W'(2));
   assign req_accept = req_tvalid && req_tready;
   assign b          = req_tdata;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {(RSP_DATA_W - $bits(rsp_fields_type))'(0), q_ff[0].f};
   assign rsp_tuser  = q_ff[0].kind;
   assign rsp_tlast  = q_ff[0].last;
   assign pop        = rsp_tvalid && rsp_tready;

   // ---- per-byte parse, state update and result build ----
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      header_crc_in   = header_crc_ff;
      header_log_in   = header_log_ff;
      header_seg_in   = header_seg_ff;
      header_type_in  = header_type_ff;
      header_size_in  = header_size_ff;
      payload_left_in = payload_left_ff;
      running_crc_in  = running_crc_ff;
      expected_in     = expected_ff;
      highest_in      = highest_ff;
      ts_segment_in   = ts_segment_ff;
      byte_offset_in  = byte_offset_ff;
      record_start_in = record_start_ff;
      crc_base        = running_crc_ff;
      done            = 1'b0;
      gap             = 1'b0;
      newer           = 1'b0;
      res_a           = '0;
      res_b           = '0;
      eof_res         = '0;
      n_res           = 2'd0;

      if (req_accept) begin
         byte_offset_in = byte_offset_ff + 64'd1;

         unique case (phase_ff)
            PH_HEADER: begin
               if (header_count_ff == '0) begin
                  record_start_in = byte_offset_ff;
                  crc_base        = CRC_INIT;
               end
               priority if (header_count_ff < HC_LOG) begin
                  header_crc_in = {header_crc_ff[23:0], b};
               end else if (header_count_ff < HC_SEG) begin
                  header_log_in = {header_log_ff[23:0], b};
               end else if (header_count_ff < HC_TYPE) begin
                  header_seg_in = {header_seg_ff[55:0], b};
               end else if (header_count_ff < HC_SIZE) begin
                  header_type_in = b;
               end else begin
                  header_size_in = {header_size_ff[23:0], b};
               end
               // stored crc bytes are not covered
               running_crc_in = (header_count_ff >= HC_LOG) ? crc_byte(crc_base, b)
                                                            : crc_base;
               if (header_count_ff >= HC_LAST) begin
                  header_count_in = '0;
                  payload_left_in = header_size_in;
                  if (header_size_in == 32'd0) begin
                     done = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  header_count_in = header_count_ff + HCNT_W'(1);
               end
            end
            PH_PAYLOAD: begin
               running_crc_in  = crc_byte(running_crc_ff, b);
               payload_left_in = payload_left_ff - 32'd1;
               if (payload_left_in == 32'd0) begin
                  done = 1'b1;
               end
            end
            default: begin
               // error tail: bytes ignored until end of file
            end
         endcase

         if (done) begin
            gap = (header_log_in != expected_ff);
            if (crc_enable_ff && (header_crc_in != ~running_crc_in)) begin
               phase_in = PH_ERROR;
               res_a = mk_beat(KIND_CRC, 1'b1, header_log_in, header_seg_in, header_type_in,
                               header_size_in, gap, 1'b0, expected_ff, highest_ff,
                               ts_segment_ff, record_start_in);
            end else begin
               if ((header_type_in == ts_code_ff) && (header_seg_in > ts_segment_ff)) begin
                  ts_segment_in = header_seg_in;
                  newer         = 1'b1;
               end
               expected_in = header_log_in + 32'd1;
               if (header_seg_in > highest_ff) begin
                  highest_in = header_seg_in;
               end
               phase_in = PH_HEADER;
               res_a = mk_beat(KIND_OK, 1'b1, header_log_in, header_seg_in, header_type_in,
                               header_size_in, gap, newer, expected_in, highest_in,
                               ts_segment_in, 64'd0);
            end
            n_res = 2'd1;
         end

         if (req_tlast) begin
            priority if (phase_in == PH_PAYLOAD) begin
               // header complete, payload cut short
               eof_res = mk_beat(KIND_TRUNC, 1'b1, header_log_in, header_seg_in,
                                 header_type_in, header_size_in, 1'b0, 1'b0, expected_in,
                                 highest_in, ts_segment_in, record_start_in);
            end else if ((phase_in == PH_HEADER) && (header_count_in != '0)) begin
               // header cut short
               eof_res = mk_beat(KIND_TRUNC, 1'b0, header_log_in, header_seg_in,
                                 header_type_in, header_size_in, 1'b0, 1'b0, expected_in,
                                 highest_in, ts_segment_in, record_start_in);
            end else if (phase_in == PH_ERROR) begin
               eof_res = mk_beat(KIND_EOF, 1'b0, header_log_in, header_seg_in,
                                 header_type_in, header_size_in, 1'b0, 1'b0, expected_in,
                                 highest_in, ts_segment_in, record_start_in);
            end else begin
               // clean file: cut point is the file length
               eof_res = mk_beat(KIND_EOF, 1'b0, header_log_in, header_seg_in,
                                 header_type_in, header_size_in, 1'b0, 1'b0, expected_in,
                                 highest_in, ts_segment_in, byte_offset_in);
            end
            if (n_res == 2'd0) begin
               res_a = eof_res;
            end else begin
               res_b = eof_res;
            end
            n_res = n_res + 2'd1;

            // next file; timestamp segment carries over
            phase_in        = PH_HEADER;
            header_count_in = '0;
            header_crc_in   = '0;
            header_log_in   = '0;
            header_seg_in   = '0;
            header_type_in  = '0;
            header_size_in  = '0;
            payload_left_in = '0;
            running_crc_in  = CRC_INIT;
            expected_in     = '0;
            highest_in      = '0;
            byte_offset_in  = '0;
            record_start_in = '0;
         end

         if (n_res == 2'd2) begin
            res_b.last = 1'b1;
         end else if (n_res == 2'd1) begin
            res_a.last = 1'b1;
         end
      end
   end

   // ---- result queue: pop from the head, push behind what stays ----
   always_comb begin
      q_shift[0] = pop ? q_ff[1] : q_ff[0];
      q_shift[1] = pop ? q_ff[2] : q_ff[1];
      q_shift[2] = q_ff[2];
      cnt_mid    = count_ff - QCNT_W'(pop);
      for (int i = 0; i < QDEPTH; i++) begin
         q_in[i] = q_shift[i];
         if ((n_res != 2'd0) && (QCNT_W'(i) == cnt_mid)) begin
            q_in[i] = res_a;
         end
         if ((n_res == 2'd2) && (QCNT_W'(i) == (cnt_mid + QCNT_W'(1)))) begin
            q_in[i] = res_b;
         end
      end
      count_in = cnt_mid + n_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_enable_ff   <= 1'b1;
         ts_code_ff      <= 8'd0;
         phase_ff        <= PH_HEADER;
         header_count_ff <= '0;
         header_crc_ff   <= '0;
         header_log_ff   <= '0;
         header_seg_ff   <= '0;
         header_type_ff  <= '0;
         header_size_ff  <= '0;
         payload_left_ff <= '0;
         running_crc_ff  <= CRC_INIT;
         expected_ff     <= '0;
         highest_ff      <= '0;
         ts_segment_ff   <= '0;
         byte_offset_ff  <= '0;
         record_start_ff <= '0;
         count_ff        <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CRC_EN:  crc_enable_ff <= csr_wdata[0];
               CSR_TS_CODE: ts_code_ff    <= csr_wdata;
               default:     ;
            endcase
         end
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         header_crc_ff   <= header_crc_in;
         header_log_ff   <= header_log_in;
         header_seg_ff   <= header_seg_in;
         header_type_ff  <= header_type_in;
         header_size_ff  <= header_size_in;
         payload_left_ff <= payload_left_in;
         running_crc_ff  <= running_crc_in;
         expected_ff     <= expected_in;
         highest_ff      <= highest_in;
         ts_segment_ff   <= ts_segment_in;
         byte_offset_ff  <= byte_offset_in;
         record_start_ff <= record_start_in;
         count_ff        <= count_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

/* rtl/core/wrp_checker.sv */
// Port-level checks for the WAL record parser, bound to the top level.
module wrp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [wrp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tlast
);
   import wrp_pkg::*;

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // end-of-file results always close the byte
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_EOF || rsp_tuser == KIND_TRUNC) |-> rsp_tlast)
      else $error("summary or truncation beat without tlast");

   // only a record result can be followed by a summary for the same byte
   a_first_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tuser == KIND_OK || rsp_tuser == KIND_CRC))
      else $error("non-final beat of unexpected kind");

   // a good record never cuts the log
   a_ok_cut: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_OK |-> rsp_tdata[361:298] == 64'd0)
      else $error("record ok with nonzero cut offset");

   // a crc failure never raises the timestamp
   a_crc_newer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_CRC |-> !rsp_tdata[137])
      else $error("crc mismatch flagged newer timestamp");

endmodule

bind wal_record_parser_crc_check wrp_checker u_wrp_checker (.*);

/* bench/wrp_result_checker.sv */
// Result checker for the WAL record parser: follows the byte stream and scores every result beat.
`timescale 1ns / 1ps
module wrp_result_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] data_byte
   input  logic                            req_tlast,   // end_of_file
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_fields_type in the low bits, rest zero
   input  logic [wrp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [1:0]                      rsp_tuser,   // kind
   input  logic                            rsp_tlast,   // final_result
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [7:0]                      csr_wdata,
   output int                              errors,
   output int                              owed
);
   import wrp_pkg::*;

   localparam int HDR_LEN  = 21;
   localparam int POS_LOG  = 4;
   localparam int POS_SEG  = 8;
   localparam int POS_TYPE = 16;
   localparam int FIELDS_W = $bits(rsp_fields_type);

   logic        crc_on;
   logic [7:0]  ts_code;

   phase_type   stage;
   int unsigned hdr_pos;
   logic [31:0] hdr_crc;
   logic [31:0] hdr_log;
   logic [63:0] hdr_seg;
   logic [7:0]  hdr_type;
   logic [31:0] hdr_size;
   logic [31:0] body_left;
   logic [31:0] crc_acc;
   logic [31:0] next_num;
   logic [63:0] max_seg;
   logic [63:0] ts_seg;
   logic [63:0] file_pos;
   logic [63:0] rec_at;

   beat_type    owed_reports[$];

   // zlib CRC-32, data bit folded into the feedback decision
   function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c;
      for (int k = 0; k < 8; k++) begin
         r = (r >> 1) ^ (32'hEDB8_8320 & {32{r[0] ^ b[k]}});
      end
      return r;
   endfunction

   function automatic beat_type make_report(input kind_type k, input bit with_hdr,
                                            input bit gap, input bit newer,
                                            input logic [63:0] cut);
      beat_type r;
      r      = '0;
      r.kind = k;
      if (with_hdr) begin
         r.f.log_number     = hdr_log;
         r.f.record_segment = hdr_seg;
         r.f.entry_type     = hdr_type;
         r.f.payload_size   = hdr_size;
      end
      r.f.number_gap        = gap;
      r.f.newer_timestamp   = newer;
      r.f.next_log_number   = next_num;
      r.f.top_segment       = max_seg;
      r.f.latest_ts_segment = ts_seg;
      r.f.cut_offset        = cut;
      return r;
   endfunction

   // all parse state but the timestamp segment starts over with each file
   task automatic clear_file();
      stage     = PH_HEADER;
      hdr_pos   = 0;
      hdr_crc   = '0;
      hdr_log   = '0;
      hdr_seg   = '0;
      hdr_type  = '0;
      hdr_size  = '0;
      body_left = '0;
      crc_acc   = '1;
      next_num  = '0;
      max_seg   = '0;
      file_pos  = '0;
      rec_at    = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic eof);
      logic [63:0] at;
      bit          done;
      bit          gap;
      bit          newer;
      beat_type    made [2];
      int          n;
      at       = file_pos;
      file_pos = file_pos + 64'd1;
      done     = 1'b0;
      n        = 0;
      case (stage)
         PH_HEADER: begin
            if (hdr_pos == 0) begin
               rec_at  = at;
               crc_acc = '1;
            end
            if (hdr_pos < POS_LOG)        hdr_crc  = {hdr_crc[23:0], b};
            else if (hdr_pos < POS_SEG)   hdr_log  = {hdr_log[23:0], b};
            else if (hdr_pos < POS_TYPE)  hdr_seg  = {hdr_seg[55:0], b};
            else if (hdr_pos == POS_TYPE) hdr_type = b;
            else                          hdr_size = {hdr_size[23:0], b};
            if (hdr_pos >= POS_LOG) crc_acc = crc_feed(crc_acc, b);
            if (hdr_pos == HDR_LEN - 1) begin
               hdr_pos   = 0;
               body_left = hdr_size;
               if (hdr_size == 0) done = 1'b1;
               else stage = PH_PAYLOAD;
            end else begin
               hdr_pos++;
            end
         end
         PH_PAYLOAD: begin
            crc_acc   = crc_feed(crc_acc, b);
            body_left = body_left - 32'd1;
            done      = (body_left == 0);
         end
         default: ;
      endcase

      if (done) begin
         gap = (hdr_log != next_num);
         if (crc_on && hdr_crc != ~crc_acc) begin
            // bad record: running values frozen, rest of file skipped
            stage   = PH_ERROR;
            made[0] = make_report(KIND_CRC, 1'b1, gap, 1'b0, rec_at);
         end else begin
            newer = (hdr_type == ts_code) && (hdr_seg > ts_seg);
            if (newer) ts_seg = hdr_seg;
            next_num = hdr_log + 32'd1;
            if (hdr_seg > max_seg) max_seg = hdr_seg;
            stage   = PH_HEADER;
            made[0] = make_report(KIND_OK, 1'b1, gap, newer, '0);
         end
         n = 1;
      end

      if (eof) begin
         if (stage == PH_PAYLOAD)
            made[n] = make_report(KIND_TRUNC, 1'b1, 1'b0, 1'b0, rec_at);
         else if (stage == PH_HEADER && hdr_pos != 0)
            made[n] = make_report(KIND_TRUNC, 1'b0, 1'b0, 1'b0, rec_at);
         else if (stage == PH_ERROR)
            made[n] = make_report(KIND_EOF, 1'b0, 1'b0, 1'b0, rec_at);
         else
            made[n] = make_report(KIND_EOF, 1'b0, 1'b0, 1'b0, file_pos);
         n++;
         clear_file();
      end

      if (n > 0) made[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) owed_reports.push_back(made[k]);
   endtask

   task automatic compare(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s differs: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic score_beat();
      beat_type       want;
      rsp_fields_type got;
      got = rsp_fields_type'(rsp_tdata[FIELDS_W-1:0]);
      if (owed_reports.size() == 0) begin
         errors++;
         $display("%0t: unexpected result beat: expected none, actual kind %0d data %h",
                  $time, rsp_tuser, rsp_tdata);
      end else begin
         want = owed_reports.pop_front();
         compare("kind", want.kind, rsp_tuser);
         compare("log_number", want.f.log_number, got.log_number);
         compare("record_segment", want.f.record_segment, got.record_segment);
         compare("entry_type", want.f.entry_type, got.entry_type);
         compare("payload_size", want.f.payload_size, got.payload_size);
         compare("number_gap", want.f.number_gap, got.number_gap);
         compare("newer_timestamp", want.f.newer_timestamp, got.newer_timestamp);
         compare("next_log_number", want.f.next_log_number, got.next_log_number);
         compare("top_segment", want.f.top_segment, got.top_segment);
         compare("latest_ts_segment", want.f.latest_ts_segment, got.latest_ts_segment);
         compare("cut_offset", want.f.cut_offset, got.cut_offset);
         compare("final_result", want.last, rsp_tlast);
         compare("tdata padding", '0, rsp_tdata[RSP_DATA_W-1:FIELDS_W]);
      end
   endtask

   // beats that complete at this edge are scored before the new byte is parsed
   always @(posedge clock) begin
      if (reset) begin
         crc_on  = 1'b1;
         ts_code = 8'd0;
         ts_seg  = '0;
         clear_file();
         owed_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) score_beat();
         if (csr_we) begin
            case (csr_index)
               CSR_CRC_EN:  crc_on  = csr_wdata[0];
               CSR_TS_CODE: ts_code = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
      end
      owed = owed_reports.size();
   end

endmodule

/* bench/wal_record_parser_crc_check_tb.sv */
// Testbench top for the WAL record parser: builds log files, drives bytes and config, gives verdict.
`timescale 1ns / 1ps
module wal_record_parser_crc_check_tb;
   import wrp_pkg::*;

   // Quiet-cycle limit: above the longest sender gap or receiver stall at 79%,
   // a settle plus two register writes, and the reset.
   localparam int QUIET_LIMIT = 5000;
   // Least number of bytes per random phase; five phases follow the directed files.
   localparam int PHASE_BYTES = 250;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'd0;   // [7:0] data_byte
   logic                   req_tlast  = 1'b0;   // end_of_file
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;           // result fields, log_number lowest, rest zero
   logic [1:0]             rsp_tuser;           // kind
   logic                   rsp_tlast;           // final_result
   logic                   csr_we     = 1'b0;
   logic                   csr_index  = 1'b0;
   logic [7:0]             csr_wdata  = 8'd0;

   int                     check_errors;
   int                     results_owed;

   // traffic shaping, percent of cycles
   int unsigned            sender_idle_pct = 0;
   int unsigned            sink_stall_pct  = 0;
   // current timestamp type setting, so records can be built to match it
   logic [7:0]             ts_pick = 8'd0;
   int unsigned            bytes_sent = 0;
   int unsigned            quiet = 0;
   // segment ids climb slowly so that timestamp records keep raising the mark
   logic [63:0]            seg_run;
   logic [7:0]             file_img[$];

   always #5 clock = ~clock;

   wal_record_parser_crc_check u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   wrp_result_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .errors     (check_errors),
      .owed       (results_owed)
   );

   // Receiver backpressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // Watchdog: any accepted beat on either side counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("wal_record_parser_crc_check: mismatch");
         $finish;
      end
   end

   // Stimulus-side CRC-32 (reflected, init and final xor all ones).
   function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = r[0] ? (r >> 1) ^ 32'hEDB8_8320 : r >> 1;
      return r;
   endfunction

   // Append one record to the file image. size_field is what the header
   // claims, body_len what is actually appended; they differ only for a
   // record that the end of file is meant to cut off. spoil flips one crc bit.
   task automatic add_record(input logic [31:0] num, input logic [63:0] seg,
                             input logic [7:0] etype, input logic [31:0] size_field,
                             input int unsigned body_len, input bit spoil);
      logic [7:0]  tail[$];
      logic [31:0] c;
      for (int k = 3; k >= 0; k--) tail.push_back(num[8*k +: 8]);
      for (int k = 7; k >= 0; k--) tail.push_back(seg[8*k +: 8]);
      tail.push_back(etype);
      for (int k = 3; k >= 0; k--) tail.push_back(size_field[8*k +: 8]);
      repeat (body_len) tail.push_back(8'($urandom));
      c = '1;
      foreach (tail[k]) c = crc_next(c, tail[k]);
      c = ~c;
      if (spoil) c[$urandom_range(31)] ^= 1'b1;
      for (int k = 3; k >= 0; k--) file_img.push_back(c[8*k +: 8]);
      foreach (tail[k]) file_img.push_back(tail[k]);
   endtask

   // One beat on req. Idle cycles go in front of the beat; tready is looked at
   // mid-cycle, so the beat counts as taken at the following rising edge.
   task automatic send_byte(input logic [7:0] b, input logic eof);
      bit rdy;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      do begin
         @(negedge clock);
         rdy = req_tready;
         @(posedge clock);
      end while (!rdy);
      bytes_sent++;
   endtask

   // The last byte of the image carries end of file.
   task automatic send_file();
      foreach (file_img[k]) send_byte(file_img[k], k == file_img.size() - 1);
   endtask

   // Sender holds off until every predicted beat has come back, then idles on so
   // that the parser can finish a byte that produced no beat.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_regs(input bit crc, input logic [7:0] ts);
      settle();
      write_reg(CSR_CRC_EN, {7'd0, crc});
      write_reg(CSR_TS_CODE, ts);
      ts_pick = ts;
   endtask

   // Mostly well-formed files: log numbers count up from zero, segment ids
   // climb, a fair share of records carry the timestamp type. Some records get
   // a bad crc, some files end early, get trailing noise, or end inside a
   // payload that claims a huge size.
   task automatic random_file();
      int unsigned nrec;
      int unsigned len;
      int unsigned keep;
      int unsigned r;
      logic [31:0] num;
      logic [63:0] seg;
      logic [7:0]  etype;
      file_img.delete();
      nrec = $urandom_range(1, 5);
      r    = $urandom_range(9);
      num  = (r < 7) ? 32'd0 : (r < 8) ? 32'hFFFF_FFFE : $urandom;
      for (int i = 0; i < nrec; i++) begin
         r = $urandom_range(99);
         if (r < 80) begin
            seg_run = seg_run + $urandom_range(1, 500);
            seg     = seg_run;
         end else if (r < 95) begin
            seg = seg_run >> $urandom_range(1, 63);
         end else begin
            seg = {$urandom, $urandom};
         end
         // full-range ids get a random type, not the picked timestamp type, or the mark would stick
         etype = (r < 95 && $urandom_range(9) < 4) ? ts_pick : 8'($urandom);
         r     = $urandom_range(99);
         len   = (r < 15) ? 0 : (r < 75) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         add_record(num, seg, etype, len, len, $urandom_range(99) < 8);
         r   = $urandom_range(99);
         num = (r < 88) ? num + 32'd1 : (r < 94) ? num + $urandom_range(2, 9) : $urandom;
      end
      case ($urandom_range(9))
         6, 7: begin
            keep = $urandom_range(1, file_img.size() - 1);
            while (file_img.size() > keep) void'(file_img.pop_back());
         end
         8: repeat ($urandom_range(1, 25)) file_img.push_back(8'($urandom));
         9: add_record(num, seg_run, ts_pick, 32'hFFFF_0000 | 32'($urandom),
                       $urandom_range(0, 6), 1'b0);
         default: ;
      endcase
      send_file();
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                            input bit crc, input logic [7:0] ts);
      int unsigned start;
      set_regs(crc, ts);
      sender_idle_pct = send_pct;
      sink_stall_pct  = stall_pct;
      start = bytes_sent;
      random_file();
      // hold the sender until the parser has answered everything so far
      settle();
      while (bytes_sent - start < PHASE_BYTES) random_file();
   endtask

   initial begin
      seg_run = {32'd0, $urandom} | 64'h100;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed files, reset register values (crc on, timestamp type 0)

      // single byte with end of file: header cut short, no header fields
      file_img.delete();
      file_img.push_back(8'hA5);
      send_file();

      // zero-size payload ending the file: record beat then summary beat
      file_img.delete();
      add_record(32'd0, 64'd5, 8'h00, 32'd0, 0, 1'b0);
      send_file();

      // top segment at all ones, a log-number gap, number wrap to zero
      file_img.delete();
      add_record(32'd0, '1, 8'hFF, 32'd3, 3, 1'b0);
      add_record(32'd7, 64'd0, 8'h00, 32'd0, 0, 1'b0);
      add_record(32'hFFFF_FFFF, 64'd9, 8'h00, 32'd1, 1, 1'b0);
      add_record(32'd0, 64'd10, 8'h00, 32'd2, 2, 1'b0);
      send_file();

      // crc mismatch mid-file, trailing bytes ignored up to end of file
      file_img.delete();
      add_record(32'd0, 64'd11, 8'h00, 32'd4, 4, 1'b0);
      add_record(32'd1, 64'd12, 8'h00, 32'd2, 2, 1'b1);
      repeat (5) file_img.push_back(8'($urandom));
      send_file();

      // crc mismatch with a gap on the file's final byte
      file_img.delete();
      add_record(32'd3, 64'd4, 8'h00, 32'd0, 0, 1'b1);
      send_file();

      // truncated inside a payload that claims the largest size
      file_img.delete();
      add_record(32'd0, 64'd20, 8'h00, 32'hFFFF_FFFF, 4, 1'b0);
      send_file();

      // truncated inside the second header
      file_img.delete();
      add_record(32'd0, 64'd21, 8'h10, 32'd1, 1, 1'b0);
      repeat (10) file_img.push_back(8'($urandom));
      send_file();

      // crc check off: a bad crc passes, timestamp type at its top value
      set_regs(1'b0, 8'hFF);
      file_img.delete();
      add_record(32'd5, 64'd30, 8'hFF, 32'd2, 2, 1'b1);
      add_record(32'd6, 64'd2, 8'hFF, 32'd0, 0, 1'b0);
      send_file();

      // ---- random phases: no idling, sender idle, receiver stall, both light, no idling again
      run_phase(0, 0, 1'b1, 8'($urandom));
      run_phase(79, 0, 1'b0, 8'hFF);
      run_phase(0, 79, 1'b1, 8'h00);
      run_phase(10, 10, 1'b1, 8'($urandom));
      run_phase(0, 0, 1'b0, 8'($urandom));

      settle();
      repeat (8) @(posedge clock);
      if (check_errors == 0) begin
         $display("wal_record_parser_crc_check: match");
      end else begin
         $display("wal_record_parser_crc_check: mismatch");
      end
      $finish;
   end

endmodule
